// ----- src/swt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_pkg
// Shared types and constants for the sorted word table seek/insert core.
// ----------------------------------------------------------------------------
package swt_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int FILL_W       = 9;
  localparam int OUT_W        = 24;
  localparam int DEF_CAPACITY = 256;

  // Bit positions of the result fields in the output tdata
  localparam int OUT_FOUND_BIT = POS_W;
  localparam int OUT_REJ_BIT   = POS_W + 1;
  localparam int OUT_FILL_LSB  = POS_W + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_COMPARE,
    S_VERIFY,
    S_SHIFT,
    S_PUT,
    S_DONE
  } state_t;

endpackage

// ----- src/sorted_word_table_seek_insert_core.sv -----
`timescale 1ns / 1ps
// A seek reads and compares once per halving step of the binary search, and skips the final
// verify read when the search ends past the last entry. An insert of an absent value then
// moves each entry above the insert point one place up, one entry per cycle through the
// table memory.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset clears the entry count and the control state; table contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_word_table_seek_insert_core
// Ascending table of 32-bit words with binary-search seek and ordered insert.
// ----------------------------------------------------------------------------
module sorted_word_table_seek_insert_core
  import swt_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [31:0] key_value
  input  logic [0:0]        s_tuser,   // [0] func (0 seek, 1 insert)
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata    // [7:0] position, [8] found, [9] rejected,
                                       // [18:10] fill_count, [23:19] zero
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t state, state_next;

  logic [CW-1:0]     count;
  logic [CW-1:0]     lo, hi;
  logic [AW-1:0]     mid_q, idx, ptr, wr_addr;
  logic              wr_pend;
  logic [DATA_W-1:0] key_q;
  logic              func_q;
  logic [AW-1:0]     res_pos;
  logic              res_found, res_rej;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0] span, mid_w;
  logic [AW-1:0] mid;
  logic          range_open, lo_in_table, not_full, hit_now, miss_here, more_to_move;
  logic [31:0]   pos_w, fill_w;

  assign span         = hi - lo;
  assign mid_w        = lo + (span >> 1);
  assign mid          = mid_w[AW-1:0];
  assign range_open   = lo < hi;
  assign lo_in_table  = lo < count;
  assign not_full     = count < CAP_C;
  assign hit_now      = (state == S_VERIFY) && (ram_rdata == key_q);
  assign miss_here    = ((state == S_PROBE) && !range_open && !lo_in_table) ||
                        ((state == S_VERIFY) && !hit_now);
  assign more_to_move = ptr > idx;
  assign pos_w        = 32'(res_pos);
  assign fill_w       = 32'(count);

  swt_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_PROBE;
      end
      S_PROBE: begin
        if (range_open) begin
          state_next = S_COMPARE;
        end else if (lo_in_table) begin
          state_next = S_VERIFY;
        end else if (func_q && not_full) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_COMPARE: state_next = S_PROBE;
      S_VERIFY: begin
        if (!hit_now && func_q && not_full) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        if (!more_to_move) state_next = S_PUT;
      end
      S_PUT: state_next = S_DONE;
      S_DONE: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    s_tready  = (state == S_IDLE);
    ram_re    = 1'b0;
    ram_raddr = mid;
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = ram_rdata;
    unique case (state)
      S_PROBE: begin
        ram_re    = 1'b1;
        ram_raddr = range_open ? mid : lo[AW-1:0];
      end
      S_SHIFT: begin
        // Read the entry below while writing the one read last cycle one place up
        ram_re    = more_to_move;
        ram_raddr = ptr - AW'(1);
        ram_we    = wr_pend;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = key_q;
      end
      default: begin
      end
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        key_q     <= s_tdata;
        func_q    <= s_tuser[0];
        lo        <= '0;
        hi        <= count;
        res_pos   <= '0;
        res_found <= 1'b0;
        res_rej   <= 1'b0;
        wr_pend   <= 1'b0;
      end
      S_PROBE: begin
        if (range_open) begin
          mid_q <= mid;
        end else begin
          idx <= lo[AW-1:0];
        end
      end
      S_COMPARE: begin
        if (ram_rdata < key_q) begin
          lo <= CW'(mid_q) + CW'(1);
        end else begin
          hi <= CW'(mid_q);
        end
      end
      S_SHIFT: begin
        if (more_to_move) begin
          wr_pend <= 1'b1;
          wr_addr <= ptr;
          ptr     <= ptr - AW'(1);
        end else begin
          wr_pend <= 1'b0;
        end
      end
      S_PUT: res_pos <= idx;
      default: begin
      end
    endcase
    if (hit_now) begin
      res_found <= 1'b1;
      res_pos   <= idx;
    end
    if (miss_here && func_q) begin
      if (not_full) begin
        ptr <= count[AW-1:0];
      end else begin
        res_rej <= 1'b1;
      end
    end
  end

  // Control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_PUT) begin
        count <= count + CW'(1);
      end
      if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {5'b0, fill_w[FILL_W-1:0], res_rej, res_found, pos_w[POS_W-1:0]};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // The entry count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("entry count above capacity");

  // The search window stays well formed
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (lo <= hi) && (hi <= count))
    else $error("search window out of order");

  // The table is only written while an insert is being carried out
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_SHIFT) || (state == S_PUT)) && func_q)
    else $error("table write outside an insert");

  // Each completed insert adds exactly one entry
  a_put_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not advance the count");

endmodule

// ----- src/swt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_ram
// Table storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swt_ram
  import swt_pkg::*;
#(
  parameter int DEPTH = DEF_CAPACITY,
  parameter int AW    = $clog2(DEF_CAPACITY)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- verif/swt_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_tb_pkg
// Request codes shared by the stimulus and the checker of the word table.
// ----------------------------------------------------------------------------
package swt_tb_pkg;

  // Carried on s_tuser[0].
  typedef enum logic [0:0] {
    OP_SEEK,
    OP_INSERT
  } swt_op_e;

endpackage

// ----- verif/swt_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_table_checker
// Watches both stream channels, keeps a mirror of the sorted word table,
// predicts the reply to every accepted request and compares each returned
// reply with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module swt_table_checker
  import swt_pkg::*;
  import swt_tb_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [31:0] key_value
  input  logic [0:0]        s_tuser,   // [0] func
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [OUT_W-1:0]  m_tdata,   // [7:0] position, [8] found, [9] rejected,
                                       // [18:10] fill_count, [23:19] zero
  output int                mismatch_count,
  output int                replies_due
);

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic              found;
    logic              rejected;
    logic [FILL_W-1:0] fill_count;
  } table_reply_t;

  localparam int PAD_W = OUT_W - OUT_FILL_LSB - FILL_W;

  logic [DATA_W-1:0] mirror_words [CAPACITY];
  int unsigned       mirror_count;
  table_reply_t      due_replies [$];

  // Binary search for the first entry not below the key, then report the match,
  // insert in order, refuse when the table is full, or report a seek miss.
  function automatic table_reply_t seek_or_insert(swt_op_e op, logic [DATA_W-1:0] key);
    table_reply_t reply;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    reply = '0;
    lo    = 0;
    hi    = mirror_count;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (mirror_words[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    if (lo < mirror_count && mirror_words[lo] == key) begin
      reply.found    = 1'b1;
      reply.position = POS_W'(lo);
    end else if (op == OP_INSERT) begin
      if (mirror_count >= CAPACITY) begin
        reply.rejected = 1'b1;
      end else begin
        for (int unsigned i = mirror_count; i > lo; i--) begin
          mirror_words[i] = mirror_words[i-1];
        end
        mirror_words[lo] = key;
        mirror_count++;
        reply.position = POS_W'(lo);
      end
    end
    reply.fill_count = FILL_W'(mirror_count);
    return reply;
  endfunction

  always @(posedge clk) begin
    table_reply_t want;
    table_reply_t got;
    if (rst) begin
      mirror_count   = 0;
      mismatch_count = 0;
      due_replies.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        due_replies.push_back(seek_or_insert(swt_op_e'(s_tuser), s_tdata));
      end
      if (m_tvalid && m_tready) begin
        got.position   = m_tdata[POS_W-1:0];
        got.found      = m_tdata[OUT_FOUND_BIT];
        got.rejected   = m_tdata[OUT_REJ_BIT];
        got.fill_count = m_tdata[OUT_FILL_LSB +: FILL_W];
        if (due_replies.size() == 0) begin
          $error("reply with no request outstanding: tdata %h", m_tdata);
          mismatch_count++;
        end else begin
          want = due_replies.pop_front();
          if (got.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, got.position);
            mismatch_count++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            mismatch_count++;
          end
          if (got.rejected !== want.rejected) begin
            $error("rejected: expected %0d, actual %0d", want.rejected, got.rejected);
            mismatch_count++;
          end
          if (got.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, actual %0d", want.fill_count, got.fill_count);
            mismatch_count++;
          end
          if (m_tdata[OUT_W-1 -: PAD_W] !== '0) begin
            $error("padding: expected 0, actual %h", m_tdata[OUT_W-1 -: PAD_W]);
            mismatch_count++;
          end
        end
      end
    end
    replies_due = due_replies.size();
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives seek and insert requests into the sorted word table core: a short
// directed run over empty, front, back and duplicate cases, then random
// requests that fill the table past capacity, under several patterns of
// sender gaps and receiver back-pressure. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
  import swt_pkg::*;
  import swt_tb_pkg::*;

  localparam int RUN_LIMIT       = 1_000_000;
  localparam int RANDOM_REQUESTS = 450;
  localparam int DRAIN_CYCLES    = 300;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic [DATA_W-1:0] s_tdata  = '0;
  logic [0:0]        s_tuser  = '0;
  logic              m_tready = 1'b0;
  logic              s_tready;
  logic              m_tvalid;
  logic [OUT_W-1:0]  m_tdata;

  int          mismatch_count;
  int          replies_due;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Keys sent with an insert request, used to aim later requests at hits.
  logic [DATA_W-1:0] inserted_keys [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_word_table_seek_insert_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  swt_table_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .replies_due    (replies_due)
  );

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_request(swt_op_e op, logic [DATA_W-1:0] key);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= key;
    do @(posedge clk); while (!s_tready);
    if (op == OP_INSERT) begin
      inserted_keys.push_back(key);
    end
  endtask

  // Mostly fresh random words for inserts; seeks lean towards keys already
  // sent and their immediate neighbours, with the extremes mixed in.
  function automatic logic [DATA_W-1:0] pick_key(int unsigned fresh_pct);
    logic [DATA_W-1:0] key;
    int unsigned       roll;
    roll = $urandom_range(99);
    if (roll < 3) begin
      key = '0;
    end else if (roll < 6) begin
      key = '1;
    end else if (inserted_keys.size() == 0 || roll < fresh_pct) begin
      key = $urandom();
    end else begin
      key = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
      if (roll % 4 == 1) begin
        key = key + 1;
      end else if (roll % 4 == 2) begin
        key = key - 1;
      end
    end
    return key;
  endfunction

  initial begin
    swt_op_e op;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    send_request(OP_SEEK,   32'h0000_0000);
    send_request(OP_SEEK,   32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_SEEK,   32'h8000_0000);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h7FFF_FFFF);
    send_request(OP_INSERT, 32'h8000_0001);
    send_request(OP_SEEK,   32'h1234_5678);
    send_request(OP_SEEK,   32'h0000_0000);
    send_request(OP_SEEK,   32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'hFFFF_FFFE);
    send_request(OP_INSERT, 32'h0000_0001);
    send_request(OP_INSERT, 32'h5555_5555);
    send_request(OP_INSERT, 32'hAAAA_AAAA);
    send_request(OP_SEEK,   32'hAAAA_AAAA);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_SEEK,   32'h7FFF_FFFE);

    // Inserts dominate so that the table fills and later inserts are refused.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i < 110) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else if (i < 220) begin
        send_idle_pct  = 60;
        recv_stall_pct = 0;
      end else if (i < 330) begin
        send_idle_pct  = 0;
        recv_stall_pct = 60;
      end else begin
        send_idle_pct  = 14;
        recv_stall_pct = 14;
      end
      if ($urandom_range(99) < 75) begin
        op = OP_INSERT;
        send_request(op, pick_key(70));
      end else begin
        op = OP_SEEK;
        send_request(op, pick_key(30));
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (replies_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
